// ----- sv/tbo_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbo_pkg
// Shared constants for the triangle/box overlap test: field widths and the
// register map of the configuration port.
// ----------------------------------------------------------------------------
package tbo_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int NORM_BITS          = 16;
   localparam int CSR_INDEX_BITS     = 3;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_BOX_MIN_X    = csr_index_type'(0);
   localparam csr_index_type CSR_BOX_MIN_Y    = csr_index_type'(1);
   localparam csr_index_type CSR_BOX_MIN_Z    = csr_index_type'(2);
   localparam csr_index_type CSR_BOX_EXTENT_X = csr_index_type'(3);
   localparam csr_index_type CSR_BOX_EXTENT_Y = csr_index_type'(4);
   localparam csr_index_type CSR_BOX_EXTENT_Z = csr_index_type'(5);

endpackage
`default_nettype wire

// ----- sv/triangle_box_overlap_test.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_box_overlap_test
// Exact triangle versus axis-aligned box overlap: plane test and three
// projected edge-function tests, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one triangle per clock while the result side does not stall, and
// returns one overlap flag per triangle, in order. Each transaction passes
// through the register stages in order, and the response is presented from
// the result register. The four register stages are: operand forming
// (edge vectors, corner offsets), 24 parallel signed multipliers, sum and sign
// decision, and the result register. A stall on the result side backs up only
// as far as the first empty stage, so the input keeps taking transactions
// while bubbles remain. The query box is written through the csr port, which
// is always ready; it must only be written while no transaction is in flight.
// ----------------------------------------------------------------------------
module triangle_box_overlap_test #(
   parameter int COORD_BITS = tbo_pkg::COORD_BITS_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,

   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire  signed [COORD_BITS-1:0]           req_v0_x,
   input  wire  signed [COORD_BITS-1:0]           req_v0_y,
   input  wire  signed [COORD_BITS-1:0]           req_v0_z,
   input  wire  signed [COORD_BITS-1:0]           req_v1_x,
   input  wire  signed [COORD_BITS-1:0]           req_v1_y,
   input  wire  signed [COORD_BITS-1:0]           req_v1_z,
   input  wire  signed [COORD_BITS-1:0]           req_v2_x,
   input  wire  signed [COORD_BITS-1:0]           req_v2_y,
   input  wire  signed [COORD_BITS-1:0]           req_v2_z,
   input  wire  signed [tbo_pkg::NORM_BITS-1:0]   req_norm_x,
   input  wire  signed [tbo_pkg::NORM_BITS-1:0]   req_norm_y,
   input  wire  signed [tbo_pkg::NORM_BITS-1:0]   req_norm_z,

   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic                                   rsp_overlaps,

   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire  [tbo_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire  [COORD_BITS-1:0]                  csr_wdata
);
   import tbo_pkg::*;

   localparam int C   = COORD_BITS;
   localparam int EW  = C + 1;        // edge vector component
   localparam int OW  = C + 2;        // corner offset
   localparam int EPW = EW + OW;      // edge product
   localparam int ESW = EPW + 1;      // edge function
   localparam int PW  = C + 2;        // plane operand
   localparam int PPW = PW + NORM_BITS;
   localparam int PDW = PPW + 2;      // plane distance

   localparam int NEXT_V[3]    = '{1, 2, 0};
   localparam int AXIS_A[3]    = '{0, 1, 2};
   localparam int AXIS_B[3]    = '{1, 2, 0};
   localparam int FLIP_AXIS[3] = '{2, 0, 1};

   // configuration
   logic signed [C-1:0] box_min_ff [3];
   logic        [C-2:0] box_ext_ff [3];

   // stage control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic en_s1, en_s2, en_s3, en_rsp;

   // stage 0 operands
   logic signed [C-1:0]         vert_in  [3][3];
   logic signed [NORM_BITS-1:0] norm_in  [3];
   logic signed [PW-1:0]        op1_in   [3];
   logic signed [PW-1:0]        op2_in   [3];
   logic signed [EW-1:0]        na_in    [3][3];
   logic signed [EW-1:0]        nb_in    [3][3];
   logic signed [OW-1:0]        oa_in    [3][3];
   logic signed [OW-1:0]        ob_in    [3][3];

   // stage 1
   logic signed [NORM_BITS-1:0] s1_norm_ff [3];
   logic signed [PW-1:0]        s1_op1_ff  [3];
   logic signed [PW-1:0]        s1_op2_ff  [3];
   logic signed [EW-1:0]        s1_na_ff   [3][3];
   logic signed [EW-1:0]        s1_nb_ff   [3][3];
   logic signed [OW-1:0]        s1_oa_ff   [3][3];
   logic signed [OW-1:0]        s1_ob_ff   [3][3];

   // stage 2
   logic signed [PPW-1:0]       s2_pp1_ff [3];
   logic signed [PPW-1:0]       s2_pp2_ff [3];
   logic signed [EPW-1:0]       s2_ea_ff  [3][3];
   logic signed [EPW-1:0]       s2_eb_ff  [3][3];

   // stage 3
   logic s3_overlap_in, s3_overlap_ff;
   logic rsp_overlaps_ff;

   // ---------------------------------------------------------------- control
   assign en_rsp    = !rsp_valid_ff || !rsp_stall;
   assign en_s3     = !s3_valid_ff  || en_rsp;
   assign en_s2     = !s2_valid_ff  || en_s3;
   assign en_s1     = !s1_valid_ff  || en_s2;
   assign req_stall = !en_s1;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_overlaps = rsp_overlaps_ff;
   assign csr_ready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_s1)  s1_valid_ff  <= req_valid;
         if (en_s2)  s2_valid_ff  <= s1_valid_ff;
         if (en_s3)  s3_valid_ff  <= s2_valid_ff;
         if (en_rsp) rsp_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------------------------------------------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            box_min_ff[k] <= '0;
            box_ext_ff[k] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BOX_MIN_X:    box_min_ff[0] <= csr_wdata;
            CSR_BOX_MIN_Y:    box_min_ff[1] <= csr_wdata;
            CSR_BOX_MIN_Z:    box_min_ff[2] <= csr_wdata;
            CSR_BOX_EXTENT_X: box_ext_ff[0] <= csr_wdata[C-2:0];
            CSR_BOX_EXTENT_Y: box_ext_ff[1] <= csr_wdata[C-2:0];
            CSR_BOX_EXTENT_Z: box_ext_ff[2] <= csr_wdata[C-2:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------ stage 0 operands
   assign vert_in[0][0] = req_v0_x;
   assign vert_in[0][1] = req_v0_y;
   assign vert_in[0][2] = req_v0_z;
   assign vert_in[1][0] = req_v1_x;
   assign vert_in[1][1] = req_v1_y;
   assign vert_in[1][2] = req_v1_z;
   assign vert_in[2][0] = req_v2_x;
   assign vert_in[2][1] = req_v2_y;
   assign vert_in[2][2] = req_v2_z;
   assign norm_in[0]    = req_norm_x;
   assign norm_in[1]    = req_norm_y;
   assign norm_in[2]    = req_norm_z;

   always_comb begin
      logic signed [PW-1:0] base;
      logic signed [PW-1:0] ext;
      logic signed [PW-1:0] crit;
      logic                 flip;
      logic signed [EW-1:0] pa, pb, qa, qb;
      for (int k = 0; k < 3; k++) begin
         base = $signed({{2{box_min_ff[k][C-1]}}, box_min_ff[k]})
              - $signed({{2{vert_in[0][k][C-1]}}, vert_in[0][k]});
         ext  = $signed({3'b000, box_ext_ff[k]});
         crit = (!norm_in[k][NORM_BITS-1] && (norm_in[k] != '0)) ? ext : '0;
         op1_in[k] = base + crit;
         op2_in[k] = base + (ext - crit);
      end
      for (int j = 0; j < 3; j++) begin
         flip = norm_in[FLIP_AXIS[j]][NORM_BITS-1];
         for (int i = 0; i < 3; i++) begin
            pa = $signed({vert_in[i][AXIS_A[j]][C-1], vert_in[i][AXIS_A[j]]});
            pb = $signed({vert_in[i][AXIS_B[j]][C-1], vert_in[i][AXIS_B[j]]});
            qa = $signed({vert_in[NEXT_V[i]][AXIS_A[j]][C-1], vert_in[NEXT_V[i]][AXIS_A[j]]});
            qb = $signed({vert_in[NEXT_V[i]][AXIS_B[j]][C-1], vert_in[NEXT_V[i]][AXIS_B[j]]});
            na_in[j][i] = flip ? (qb - pb) : (pb - qb);
            nb_in[j][i] = flip ? (pa - qa) : (qa - pa);
            // best corner: add the extent where the edge normal points outward
            oa_in[j][i] = $signed({{2{box_min_ff[AXIS_A[j]][C-1]}}, box_min_ff[AXIS_A[j]]})
                        - $signed({pa[EW-1], pa})
                        + ((!na_in[j][i][EW-1] && (na_in[j][i] != '0))
                           ? $signed({3'b000, box_ext_ff[AXIS_A[j]]}) : $signed({OW{1'b0}}));
            ob_in[j][i] = $signed({{2{box_min_ff[AXIS_B[j]][C-1]}}, box_min_ff[AXIS_B[j]]})
                        - $signed({pb[EW-1], pb})
                        + ((!nb_in[j][i][EW-1] && (nb_in[j][i] != '0))
                           ? $signed({3'b000, box_ext_ff[AXIS_B[j]]}) : $signed({OW{1'b0}}));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_s1) begin
         s1_norm_ff <= norm_in;
         s1_op1_ff  <= op1_in;
         s1_op2_ff  <= op2_in;
         s1_na_ff   <= na_in;
         s1_nb_ff   <= nb_in;
         s1_oa_ff   <= oa_in;
         s1_ob_ff   <= ob_in;
      end
   end

   // ------------------------------------------------------ stage 2 products
   always_ff @(posedge clock) begin
      if (en_s2) begin
         for (int k = 0; k < 3; k++) begin
            s2_pp1_ff[k] <= PPW'(s1_norm_ff[k]) * PPW'(s1_op1_ff[k]);
            s2_pp2_ff[k] <= PPW'(s1_norm_ff[k]) * PPW'(s1_op2_ff[k]);
         end
         for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
               s2_ea_ff[j][i] <= EPW'(s1_na_ff[j][i]) * EPW'(s1_oa_ff[j][i]);
               s2_eb_ff[j][i] <= EPW'(s1_nb_ff[j][i]) * EPW'(s1_ob_ff[j][i]);
            end
         end
      end
   end

   // ------------------------------------------------- stage 3 sums and signs
   always_comb begin
      logic signed [PDW-1:0] d1, d2;
      logic signed [ESW-1:0] es;
      logic                  ok;
      d1 = PDW'(s2_pp1_ff[0]) + PDW'(s2_pp1_ff[1]) + PDW'(s2_pp1_ff[2]);
      d2 = PDW'(s2_pp2_ff[0]) + PDW'(s2_pp2_ff[1]) + PDW'(s2_pp2_ff[2]);
      // both corners strictly on one side of the plane
      ok = !((d1 != '0) && (d2 != '0) && (d1[PDW-1] == d2[PDW-1]));
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            es = ESW'(s2_ea_ff[j][i]) + ESW'(s2_eb_ff[j][i]);
            ok = ok && !es[ESW-1];
         end
      end
      s3_overlap_in = ok;
   end

   always_ff @(posedge clock) begin
      if (en_s3) begin
         s3_overlap_ff <= s3_overlap_in;
      end
      if (en_rsp) begin
         rsp_overlaps_ff <= s3_overlap_ff;
      end
   end

   // ------------------------------------------------------------- assertions
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_valid_ff))
      else $error("input stalled with a bubble in the pipeline");

   a_occupancy_grows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !(rsp_valid && !rsp_stall))
      |=> $countones({s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff})
          == $past($countones({s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff})) + 1)
      else $error("accepted transaction lost in the pipeline");

   a_stage3_holds: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !en_s3) |=> (s3_valid_ff && $stable(s3_overlap_ff)))
      else $error("stalled stage 3 result changed");

endmodule
`default_nettype wire
